### hdl/swb_pkg.sv
// ----------------------------------------------------------------------------
// swb_pkg: shared types and constants of the two-wire sensor bus master
// Item, configuration and result records, command codes and field widths.
// ----------------------------------------------------------------------------
package swb_pkg;

   localparam int TIMER_WIDTH    = 24;
   localparam int COMMAND_BITS   = 8;
   localparam int READ_BITS      = 16;
   localparam int BYTE_BITS      = 8;
   localparam int RESET_CLOCKS   = 9;

   localparam int REQ_TDATA_W    = 8;
   localparam int RSP_TDATA_W    = 24;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 24;

   // sensor command bytes
   localparam logic [COMMAND_BITS-1:0] CMD_TEMP = 8'h03;
   localparam logic [COMMAND_BITS-1:0] CMD_HUMI = 8'h05;
   localparam logic [COMMAND_BITS-1:0] CMD_NONE = 8'h00;

   // input kind
   localparam logic KIND_TICK    = 1'b0;
   localparam logic KIND_REQUEST = 1'b1;

   // request codes
   localparam logic [1:0] REQ_TEMP    = 2'd0;
   localparam logic [1:0] REQ_HUMI    = 2'd1;
   localparam logic [1:0] REQ_CONNRST = 2'd2;
   localparam logic [1:0] REQ_UNUSED  = 2'd3;

   // error codes
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_NO_ACK  = 2'd1;
   localparam logic [1:0] ERR_NO_REL  = 2'd2;
   localparam logic [1:0] ERR_TIMEOUT = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_PERIOD   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE        = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLL_INTERVAL = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLL_LIMIT    = 2'd3;

   typedef struct packed {
      logic [15:0] half_period_ticks;
      logic [23:0] settle_ticks;
      logic [15:0] poll_interval_ticks;
      logic [7:0]  poll_limit;
   } swb_cfg_type;

   typedef struct packed {
      logic       kind;
      logic [1:0] command;
      logic       data_in;
   } swb_item_type;

   typedef struct packed {
      logic [1:0]           error;
      logic [READ_BITS-1:0] raw_value;
      logic                 done_res;
      logic                 busy_res;
      logic                 data_out;
      logic                 data_oe;
      logic                 sck;
   } swb_result_type;

endpackage

### hdl/swb_csr.sv
// ----------------------------------------------------------------------------
// swb_csr: configuration registers
// Timing and polling registers, written through the csr channel.
// ----------------------------------------------------------------------------
module swb_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [swb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [swb_pkg::CSR_DATA_W-1:0]  csr_data,
   output swb_pkg::swb_cfg_type            cfg
);
   import swb_pkg::*;

   swb_cfg_type cfg_ff;
   swb_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_HALF_PERIOD:   cfg_in.half_period_ticks   = csr_data[15:0];
            CSR_SETTLE:        cfg_in.settle_ticks        = csr_data[23:0];
            CSR_POLL_INTERVAL: cfg_in.poll_interval_ticks = csr_data[15:0];
            CSR_POLL_LIMIT:    cfg_in.poll_limit          = csr_data[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period_ticks   <= 16'd10;
         cfg_ff.settle_ticks        <= 24'd330000;
         cfg_ff.poll_interval_ticks <= 16'd10;
         cfg_ff.poll_limit          <= 8'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hdl/swb_core.sv
// ----------------------------------------------------------------------------
// swb_core: bus sequencer
// Steps the phase machine once per registered item and forms its result.
// ----------------------------------------------------------------------------
module swb_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  swb_pkg::swb_item_type   item,
   input  swb_pkg::swb_cfg_type    cfg,
   output swb_pkg::swb_result_type result
);
   import swb_pkg::*;

   typedef enum logic [4:0] {
      P_IDLE, P_RST_LO, P_RST_HI,
      P_TS0, P_TS1, P_TS2, P_TS3, P_TS4, P_TS5, P_TS6,
      P_CMD_LO, P_CMD_HI, P_SETTLE, P_ACK_HI, P_ACK_LO, P_POLL,
      P_READ_LO, P_READ_HI, P_MACK_LO, P_MACK_HI, P_CRC_LO, P_CRC_HI
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0]  tick_ff, tick_in, tick_inc, len;
   logic [3:0]              bit_ff, bit_in, bit_inc;
   logic [READ_BITS-1:0]    shreg_ff, shreg_in;
   logic [7:0]              poll_ff, poll_in, poll_inc, poll_lim;
   logic [COMMAND_BITS-1:0] cmd_ff, cmd_in;
   logic [1:0]              err_ff, err_in;
   logic                    done;
   logic                    sck, oe, dout;

   assign tick_inc = tick_ff + 1'b1;
   assign bit_inc  = bit_ff + 4'd1;
   assign poll_inc = poll_ff + 8'd1;
   assign poll_lim = (cfg.poll_limit == 8'd0) ? 8'd1 : cfg.poll_limit;

   // phase length, zero treated as one tick
   always_comb begin
      priority if (phase_ff == P_SETTLE) begin
         len = TIMER_WIDTH'(cfg.settle_ticks);
      end else if (phase_ff == P_POLL) begin
         len = TIMER_WIDTH'(cfg.poll_interval_ticks);
      end else begin
         len = TIMER_WIDTH'(cfg.half_period_ticks);
      end
      if (len == '0) len = TIMER_WIDTH'(1);
   end

   // pin drive of the current phase
   always_comb begin
      sck  = 1'b0;
      oe   = 1'b0;
      dout = 1'b0;
      unique case (phase_ff)
         P_RST_LO, P_TS0, P_TS6, P_CRC_LO: begin
            oe = 1'b1; dout = 1'b1;
         end
         P_RST_HI, P_TS1, P_TS5, P_CRC_HI: begin
            sck = 1'b1; oe = 1'b1; dout = 1'b1;
         end
         P_TS2, P_TS4, P_MACK_HI: begin
            sck = 1'b1; oe = 1'b1;
         end
         P_TS3, P_MACK_LO: begin
            oe = 1'b1;
         end
         P_CMD_LO: begin
            oe = 1'b1; dout = shreg_ff[COMMAND_BITS-1];
         end
         P_CMD_HI: begin
            sck = 1'b1; oe = 1'b1; dout = shreg_ff[COMMAND_BITS-1];
         end
         P_ACK_HI, P_READ_HI: begin
            sck = 1'b1;
         end
         default: begin
            sck = 1'b0;
         end
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      shreg_in = shreg_ff;
      poll_in  = poll_ff;
      cmd_in   = cmd_ff;
      err_in   = err_ff;
      done     = 1'b0;
      if (step) begin
         if (item.kind == KIND_REQUEST) begin
            if (phase_ff == P_IDLE && item.command != REQ_UNUSED) begin
               unique case (item.command)
                  REQ_TEMP: cmd_in = CMD_TEMP;
                  REQ_HUMI: cmd_in = CMD_HUMI;
                  default:  cmd_in = CMD_NONE;
               endcase
               tick_in  = '0;
               bit_in   = '0;
               poll_in  = '0;
               err_in   = ERR_NONE;
               phase_in = (item.command == REQ_CONNRST) ? P_RST_LO : P_TS0;
            end
         end else if (phase_ff != P_IDLE) begin
            tick_in = tick_inc;
            if (tick_inc >= len) begin
               tick_in = '0;
               unique case (phase_ff)
                  P_RST_LO:  phase_in = P_RST_HI;
                  P_RST_HI: begin
                     if (bit_inc >= 4'(RESET_CLOCKS)) begin
                        bit_in   = '0;
                        phase_in = P_TS0;
                     end else begin
                        bit_in   = bit_inc;
                        phase_in = P_RST_LO;
                     end
                  end
                  P_TS0:     phase_in = P_TS1;
                  P_TS1:     phase_in = P_TS2;
                  P_TS2:     phase_in = P_TS3;
                  P_TS3:     phase_in = P_TS4;
                  P_TS4:     phase_in = P_TS5;
                  P_TS5:     phase_in = P_TS6;
                  P_TS6: begin
                     if (cmd_ff == CMD_NONE) begin
                        phase_in = P_IDLE; bit_in = '0; poll_in = '0;
                        err_in = ERR_NONE; done = 1'b1;
                     end else begin
                        shreg_in = READ_BITS'(cmd_ff);
                        bit_in   = '0;
                        phase_in = P_CMD_LO;
                     end
                  end
                  P_CMD_LO:  phase_in = P_CMD_HI;
                  P_CMD_HI: begin
                     shreg_in = {shreg_ff[READ_BITS-2:0], 1'b0};
                     if (bit_inc >= 4'(COMMAND_BITS)) begin
                        bit_in   = '0;
                        phase_in = (cfg.settle_ticks != '0) ? P_SETTLE : P_ACK_HI;
                     end else begin
                        bit_in   = bit_inc;
                        phase_in = P_CMD_LO;
                     end
                  end
                  P_SETTLE:  phase_in = P_ACK_HI;
                  P_ACK_HI: begin
                     if (item.data_in) begin
                        phase_in = P_IDLE; bit_in = '0; poll_in = '0;
                        err_in = ERR_NO_ACK; done = 1'b1;
                     end else begin
                        phase_in = P_ACK_LO;
                     end
                  end
                  P_ACK_LO: begin
                     if (!item.data_in) begin
                        phase_in = P_IDLE; bit_in = '0; poll_in = '0;
                        err_in = ERR_NO_REL; done = 1'b1;
                     end else begin
                        poll_in  = '0;
                        phase_in = P_POLL;
                     end
                  end
                  P_POLL: begin
                     poll_in = poll_inc;
                     if (!item.data_in) begin
                        shreg_in = '0;
                        bit_in   = '0;
                        phase_in = P_READ_LO;
                     end else if (poll_inc >= poll_lim) begin
                        phase_in = P_IDLE; bit_in = '0; poll_in = '0;
                        err_in = ERR_TIMEOUT; done = 1'b1;
                     end
                  end
                  P_READ_LO: phase_in = P_READ_HI;
                  P_READ_HI: begin
                     shreg_in = {shreg_ff[READ_BITS-2:0], item.data_in};
                     if (bit_ff == 4'(READ_BITS - 1)) begin
                        bit_in   = '0;
                        phase_in = P_CRC_LO;
                     end else begin
                        bit_in   = bit_inc;
                        phase_in = (bit_inc == 4'(BYTE_BITS)) ? P_MACK_LO : P_READ_LO;
                     end
                  end
                  P_MACK_LO: phase_in = P_MACK_HI;
                  P_MACK_HI: phase_in = P_READ_LO;
                  P_CRC_LO:  phase_in = P_CRC_HI;
                  default: begin
                     // end of CRC clock, or an unused code
                     phase_in = P_IDLE; bit_in = '0; poll_in = '0;
                     err_in = ERR_NONE; done = 1'b1;
                  end
               endcase
            end
         end
      end
   end

   always_comb begin
      result.sck      = sck;
      result.data_oe  = oe;
      result.data_out = dout;
      result.busy_res = (phase_in != P_IDLE);
      result.done_res = done;
      result.raw_value = (done && err_in == ERR_NONE && cmd_in != CMD_NONE) ?
                         shreg_in : '0;
      result.error    = done ? err_in : ERR_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         tick_ff  <= '0;
         bit_ff   <= '0;
         shreg_ff <= '0;
         poll_ff  <= '0;
         cmd_ff   <= CMD_NONE;
         err_ff   <= ERR_NONE;
      end else begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shreg_ff <= shreg_in;
         poll_ff  <= poll_in;
         cmd_ff   <= cmd_in;
         err_ff   <= err_in;
      end
   end

`ifndef SYNTHESIS
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      step && done |=> phase_ff == P_IDLE && tick_ff == '0)
      else $error("finished transaction left the sequencer busy");

   a_no_step_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(shreg_ff) && $stable(tick_ff))
      else $error("state moved without an item");

   a_tick_below_len: assert property (@(posedge clock) disable iff (reset)
      phase_ff != P_IDLE && step && item.kind == KIND_TICK |-> tick_ff < len)
      else $error("tick counter passed the phase length");

   a_error_on_done: assert property (@(posedge clock) disable iff (reset)
      result.error != ERR_NONE || result.raw_value != '0 |-> result.done_res)
      else $error("status reported without done");
`endif

endmodule

### hdl/sensor_two_wire_bus_master.sv
// ----------------------------------------------------------------------------
// sensor_two_wire_bus_master: bit-level master for a two-wire sensor bus
//
//   channel | direction | contents
//   req     | in        | tick with sampled data pin, or start request
//   rsp     | out       | pin drive and status, one per req transfer
//   csr     | in        | register index and write data
//
// Each req transfer gives one rsp transfer through the input and result registers;
// a new item is taken every cycle while req_tready is high, one swb_core step each.
// The input and result registers decouple the sides: req_tready drops only
// while both hold an item and rsp_tready is low.
// Reset is synchronous and puts the sequencer idle with default timing.
// ----------------------------------------------------------------------------
module sensor_two_wire_bus_master (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [swb_pkg::REQ_TDATA_W-1:0] req_tdata,  // command[1:0], data_in[2]
   input  logic                            req_tuser,  // kind[0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // sck[0], data_oe[1], data_out[2], busy_res[3], done_res[4],
   // raw_value[20:5], error[22:21]
   output logic [swb_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [swb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [swb_pkg::CSR_DATA_W-1:0]  csr_data
);
   import swb_pkg::*;

   swb_cfg_type    cfg;
   swb_item_type   item_ff, item_in;
   logic           req_valid_ff;
   swb_result_type result, rsp_data_ff;
   logic           rsp_valid_ff;
   logic           advance;

   swb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   swb_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   assign item_in.kind    = req_tuser;
   assign item_in.command = req_tdata[1:0];
   assign item_in.data_in = req_tdata[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff.error, rsp_data_ff.raw_value,
                        rsp_data_ff.done_res, rsp_data_ff.busy_res,
                        rsp_data_ff.data_out, rsp_data_ff.data_oe, rsp_data_ff.sck};

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: two-wire sensor bus master
// Sends start requests and timing ticks, answers the data pin like a sensor
// would (acknowledge, release, data ready, read bits), and checks every pin
// drive and status transfer against an in-bench model of the sequencer.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import swb_pkg::*;

   localparam int          WATCHDOG_CYCLES = 2000000;
   localparam int          RANDOM_TICKS    = 400;
   localparam int          MAX_PRINTED     = 40;
   localparam logic [31:0] TIMER_MAX       = (32'd1 << TIMER_WIDTH) - 32'd1;

   // content of the two bytes the sensor returns
   localparam int FILL_RANDOM = 0;
   localparam int FILL_ZERO   = 1;
   localparam int FILL_ONE    = 2;

   typedef enum logic [4:0] {
      PH_IDLE, PH_RST_LO, PH_RST_HI,
      PH_TS0, PH_TS1, PH_TS2, PH_TS3, PH_TS4, PH_TS5, PH_TS6,
      PH_CMD_LO, PH_CMD_HI, PH_SETTLE, PH_ACK_HI, PH_ACK_LO, PH_POLL,
      PH_READ_LO, PH_READ_HI, PH_MACK_LO, PH_MACK_HI, PH_CRC_LO, PH_CRC_HI
   } bus_phase_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // command[1:0], data_in[2]
   logic                   req_tuser;   // kind[0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // sck[0], data_oe[1], data_out[2], busy_res[3], done_res[4],
   // raw_value[20:5], error[22:21]
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // sequencer model state
   swb_cfg_type            cfg;
   bus_phase_type          ph;
   logic [TIMER_WIDTH-1:0] tcount;
   logic [3:0]             bcount;
   logic [15:0]            shreg;
   logic [7:0]             pcount;
   logic [7:0]             cmdb;
   logic [1:0]             errr;
   logic                   xfer_done;

   swb_result_type bus_results_due[$];

   // sensor behavior for the running transaction
   logic [1:0] fault_mode;
   int         read_fill;
   int         ready_polls;

   logic idle_off = 1'b0;
   int   busy_ticks = 0;
   int   mismatch_count = 0;
   int   result_count = 0;
   int   cycle_count = 0;

   sensor_two_wire_bus_master i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > WATCHDOG_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model

   function automatic logic [TIMER_WIDTH-1:0] phase_len_of(bus_phase_type p);
      logic [31:0] v;
      if (p == PH_SETTLE)
         v = 32'(cfg.settle_ticks);
      else if (p == PH_POLL)
         v = 32'(cfg.poll_interval_ticks);
      else
         v = 32'(cfg.half_period_ticks);
      if (v == 32'd0) v = 32'd1;
      if (v > TIMER_MAX) v = TIMER_MAX;
      return v[TIMER_WIDTH-1:0];
   endfunction

   function automatic void end_transfer(logic [1:0] e);
      ph = PH_IDLE;
      tcount = '0;
      bcount = '0;
      pcount = '0;
      errr = e;
      xfer_done = 1'b1;
   endfunction

   function automatic void advance_phase(logic din);
      logic [7:0] limit;
      case (ph)
         PH_RST_LO: ph = PH_RST_HI;
         PH_RST_HI: begin
            bcount = bcount + 4'd1;
            if (bcount >= RESET_CLOCKS) begin
               bcount = '0;
               ph = PH_TS0;
            end else begin
               ph = PH_RST_LO;
            end
         end
         PH_TS0, PH_TS1, PH_TS2, PH_TS3, PH_TS4, PH_TS5: ph = bus_phase_type'(ph + 5'd1);
         PH_TS6: begin
            if (cmdb == CMD_NONE) begin
               end_transfer(ERR_NONE);
            end else begin
               shreg = {8'd0, cmdb};
               bcount = '0;
               ph = PH_CMD_LO;
            end
         end
         PH_CMD_LO: ph = PH_CMD_HI;
         PH_CMD_HI: begin
            shreg = {shreg[14:0], 1'b0};
            bcount = bcount + 4'd1;
            if (bcount >= COMMAND_BITS) begin
               bcount = '0;
               ph = (cfg.settle_ticks != 0) ? PH_SETTLE : PH_ACK_HI;
            end else begin
               ph = PH_CMD_LO;
            end
         end
         PH_SETTLE: ph = PH_ACK_HI;
         PH_ACK_HI: begin
            if (din) end_transfer(ERR_NO_ACK);
            else ph = PH_ACK_LO;
         end
         PH_ACK_LO: begin
            if (!din) begin
               end_transfer(ERR_NO_REL);
            end else begin
               pcount = '0;
               ph = PH_POLL;
            end
         end
         PH_POLL: begin
            limit = (cfg.poll_limit != 0) ? cfg.poll_limit : 8'd1;
            pcount = pcount + 8'd1;
            if (!din) begin
               shreg = '0;
               bcount = '0;
               ph = PH_READ_LO;
            end else if (pcount >= limit) begin
               end_transfer(ERR_TIMEOUT);
            end
         end
         PH_READ_LO: ph = PH_READ_HI;
         PH_READ_HI: begin
            shreg = {shreg[14:0], din};
            if (bcount == 4'd15) begin
               bcount = '0;
               ph = PH_CRC_LO;
            end else begin
               bcount = bcount + 4'd1;
               ph = (bcount == BYTE_BITS) ? PH_MACK_LO : PH_READ_LO;
            end
         end
         PH_MACK_LO: ph = PH_MACK_HI;
         PH_MACK_HI: ph = PH_READ_LO;
         PH_CRC_LO: ph = PH_CRC_HI;
         default: end_transfer(ERR_NONE);
      endcase
   endfunction

   // One transfer of the sequencer: pins of the current phase, then the step.
   function automatic swb_result_type sensor_bus_step(swb_item_type it);
      swb_result_type res;
      res = '0;
      case (ph)
         PH_RST_LO, PH_TS0, PH_TS6, PH_CRC_LO:   {res.sck, res.data_oe, res.data_out} = 3'b011;
         PH_RST_HI, PH_TS1, PH_TS5, PH_CRC_HI:   {res.sck, res.data_oe, res.data_out} = 3'b111;
         PH_TS2, PH_TS4, PH_CMD_HI, PH_MACK_HI:  {res.sck, res.data_oe, res.data_out} = 3'b110;
         PH_TS3, PH_CMD_LO, PH_MACK_LO:          {res.sck, res.data_oe, res.data_out} = 3'b010;
         PH_ACK_HI, PH_READ_HI:                  {res.sck, res.data_oe, res.data_out} = 3'b100;
         default:                                {res.sck, res.data_oe, res.data_out} = 3'b000;
      endcase
      if (ph == PH_CMD_LO || ph == PH_CMD_HI) res.data_out = shreg[COMMAND_BITS-1];

      xfer_done = 1'b0;
      if (it.kind == KIND_REQUEST) begin
         if (ph == PH_IDLE && it.command != REQ_UNUSED) begin
            cmdb = (it.command == REQ_TEMP) ? CMD_TEMP :
                   (it.command == REQ_HUMI) ? CMD_HUMI : CMD_NONE;
            tcount = '0;
            bcount = '0;
            pcount = '0;
            errr = ERR_NONE;
            ph = (it.command == REQ_CONNRST) ? PH_RST_LO : PH_TS0;
         end
      end else if (ph != PH_IDLE) begin
         tcount = tcount + 1'b1;
         if (tcount >= phase_len_of(ph)) begin
            tcount = '0;
            advance_phase(it.data_in);
         end
      end

      res.busy_res = (ph != PH_IDLE);
      res.done_res = xfer_done;
      res.raw_value = (xfer_done && errr == ERR_NONE && cmdb != CMD_NONE) ? shreg : '0;
      res.error = xfer_done ? errr : ERR_NONE;
      return res;
   endfunction

   // Data pin as the sensor drives it; only the last tick of a phase is sampled.
   function automatic logic sensor_pin();
      logic sampled;
      sampled = ({8'd0, tcount} + 32'd1 >= {8'd0, phase_len_of(ph)});
      if (!sampled) return 1'($urandom_range(1));
      case (ph)
         PH_ACK_HI:  return (fault_mode == ERR_NO_ACK);
         PH_ACK_LO:  return (fault_mode != ERR_NO_REL);
         PH_POLL:    return (fault_mode == ERR_TIMEOUT || pcount < ready_polls);
         PH_READ_HI: begin
            if (read_fill == FILL_ONE) return 1'b1;
            if (read_fill == FILL_ZERO) return 1'b0;
            return 1'($urandom_range(1));
         end
         default:    return 1'($urandom_range(1));
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("MISMATCH at result %0d: %s", result_count, msg);
   endtask

   task automatic check_field(string name, int unsigned got, int unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   task automatic check_result();
      swb_result_type got;
      swb_result_type want;
      got = swb_result_type'(rsp_tdata[$bits(swb_result_type)-1:0]);
      if (bus_results_due.size() == 0) begin
         report_mismatch("result transfer with nothing pending");
      end else begin
         want = bus_results_due.pop_front();
         check_field("sck", got.sck, want.sck);
         check_field("data_oe", got.data_oe, want.data_oe);
         check_field("data_out", got.data_out, want.data_out);
         check_field("busy_res", got.busy_res, want.busy_res);
         check_field("done_res", got.done_res, want.done_res);
         check_field("raw_value", got.raw_value, want.raw_value);
         check_field("error", got.error, want.error);
      end
      result_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result();
      rsp_tready <= idle_off ? 1'b1 : ($urandom_range(99) >= 17);
   end

   // ---------------------------------------------------------------- drivers

   // Leaves req_tvalid high after the transfer; the next call or wait_drain
   // takes it over.
   task automatic send_item(logic kind, logic [1:0] cmd, logic din);
      swb_item_type it;
      if (!idle_off) begin
         while ($urandom_range(99) < 17) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {{(REQ_TDATA_W-3){1'b0}}, din, cmd};
      do @(posedge clock); while (!req_tready);
      it.kind = kind;
      it.command = cmd;
      it.data_in = din;
      bus_results_due.push_back(sensor_bus_step(it));
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (bus_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_HALF_PERIOD:   cfg.half_period_ticks = value[15:0];
         CSR_SETTLE:        cfg.settle_ticks = value[23:0];
         CSR_POLL_INTERVAL: cfg.poll_interval_ticks = value[15:0];
         CSR_POLL_LIMIT:    cfg.poll_limit = value[7:0];
         default: ;
      endcase
   endtask

   task automatic write_config(logic [15:0] half, logic [23:0] settle,
                               logic [15:0] interval, logic [7:0] limit);
      wait_drain();
      write_reg(CSR_HALF_PERIOD, {8'd0, half});
      write_reg(CSR_SETTLE, settle);
      write_reg(CSR_POLL_INTERVAL, {8'd0, interval});
      write_reg(CSR_POLL_LIMIT, {16'd0, limit});
   endtask

   // Ticks and unused requests while idle; the block must stay put.
   task automatic idle_noise(int n);
      repeat (n) begin
         if ($urandom_range(3) == 0)
            send_item(KIND_REQUEST, REQ_UNUSED, 1'($urandom_range(1)));
         else
            send_item(KIND_TICK, 2'($urandom_range(3)), 1'($urandom_range(1)));
      end
   endtask

   // Start one transaction and tick it to the end, with stray requests mixed in.
   task automatic run_transaction(logic [1:0] cmd, logic [1:0] flt, int fill, int polls);
      fault_mode = flt;
      read_fill = fill;
      ready_polls = polls;
      send_item(KIND_REQUEST, cmd, 1'($urandom_range(1)));
      while (ph != PH_IDLE) begin
         if ($urandom_range(99) < 3) begin
            send_item(KIND_REQUEST, 2'($urandom_range(3)), 1'($urandom_range(1)));
         end else begin
            send_item(KIND_TICK, 2'($urandom_range(3)), sensor_pin());
            busy_ticks++;
         end
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_connection_reset();
      // default timing from reset
      idle_noise(6);
      run_transaction(REQ_CONNRST, ERR_NONE, FILL_RANDOM, 0);
      idle_noise(3);
   endtask

   task automatic test_measurement_values();
      write_config(16'd1, 24'd0, 16'd1, 8'd1);
      run_transaction(REQ_TEMP, ERR_NONE, FILL_ZERO, 0);
      run_transaction(REQ_HUMI, ERR_NONE, FILL_ONE, 0);
      // zero half period, interval and limit each count as one
      write_config(16'd0, 24'd3, 16'd0, 8'd0);
      run_transaction(REQ_TEMP, ERR_NONE, FILL_RANDOM, 0);
      write_config(16'd2, 24'd5, 16'd3, 8'd4);
      run_transaction(REQ_HUMI, ERR_NONE, FILL_RANDOM, 3);
      run_transaction(REQ_CONNRST, ERR_NONE, FILL_RANDOM, 0);
   endtask

   task automatic test_bus_errors();
      write_config(16'd1, 24'd2, 16'd1, 8'd3);
      run_transaction(REQ_TEMP, ERR_NO_ACK, FILL_RANDOM, 0);
      run_transaction(REQ_HUMI, ERR_NO_REL, FILL_RANDOM, 0);
      run_transaction(REQ_TEMP, ERR_TIMEOUT, FILL_RANDOM, 0);
      write_config(16'd1, 24'd0, 16'd1, 8'd255);
      run_transaction(REQ_HUMI, ERR_TIMEOUT, FILL_RANDOM, 0);
      // ready on the very last allowed poll
      run_transaction(REQ_TEMP, ERR_NONE, FILL_RANDOM, 254);
      write_config(16'd1, 24'd0, 16'd100, 8'd1);
      run_transaction(REQ_HUMI, ERR_TIMEOUT, FILL_RANDOM, 0);
   endtask

   task automatic test_register_extremes();
      write_config(16'd65535, 24'hFFFFFF, 16'd65535, 8'd255);
      idle_noise(20);
      write_config(16'd2, 24'd100, 16'd20, 8'd5);
      run_transaction(REQ_HUMI, ERR_NONE, FILL_RANDOM, 3);
      run_transaction(REQ_CONNRST, ERR_NONE, FILL_RANDOM, 0);
   endtask

   task automatic test_random_traffic();
      int start_ticks;
      int n;
      int r;
      int limit_eff;
      logic [1:0] cmd;
      logic [1:0] flt;
      start_ticks = busy_ticks;
      n = 0;
      idle_off = 1'b1;
      while (busy_ticks - start_ticks < RANDOM_TICKS) begin
         if (busy_ticks - start_ticks > 150) idle_off = 1'b0;
         if (n % 4 == 0) begin
            write_config(16'($urandom_range(0, 3)),
                         ($urandom_range(3) == 0) ? 24'd0 : 24'($urandom_range(1, 12)),
                         16'($urandom_range(0, 3)),
                         ($urandom_range(9) == 0) ? 8'd255 : 8'($urandom_range(0, 6)));
         end
         r = $urandom_range(99);
         cmd = (r < 45) ? REQ_TEMP : (r < 90) ? REQ_HUMI : REQ_CONNRST;
         r = $urandom_range(99);
         flt = (r < 70) ? ERR_NONE : (r < 80) ? ERR_NO_ACK : (r < 90) ? ERR_NO_REL : ERR_TIMEOUT;
         limit_eff = (cfg.poll_limit != 0) ? cfg.poll_limit : 1;
         r = $urandom_range(9);
         run_transaction(cmd, flt, (r == 0) ? FILL_ZERO : (r == 1) ? FILL_ONE : FILL_RANDOM,
                         $urandom_range(0, limit_eff - 1));
         if ($urandom_range(3) == 0) idle_noise($urandom_range(1, 4));
         n++;
      end
      idle_off = 1'b0;
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      cfg.half_period_ticks = 16'd10;
      cfg.settle_ticks = 24'd330000;
      cfg.poll_interval_ticks = 16'd10;
      cfg.poll_limit = 8'd100;
      ph = PH_IDLE;
      tcount = '0;
      bcount = '0;
      shreg = '0;
      pcount = '0;
      cmdb = CMD_NONE;
      errr = ERR_NONE;
      xfer_done = 1'b0;
      fault_mode = ERR_NONE;
      read_fill = FILL_RANDOM;
      ready_polls = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_connection_reset();
      test_measurement_values();
      test_bus_errors();
      test_register_extremes();
      test_random_traffic();

      wait_drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### sim.f
hdl/swb_pkg.sv
hdl/swb_csr.sv
hdl/swb_core.sv
hdl/sensor_two_wire_bus_master.sv
tb/testbench.sv
